@@ rtl/blist_pkg.sv @@
package blist_pkg;

    localparam int COUNT_W = 8;
    localparam int VALUE_W = 32;

    localparam logic signed [VALUE_W-1:0] MAX_NEG = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_DELETE = 2'd2,
        OP_MAX    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2
    } status_t;

    typedef struct packed {
        op_t                       op;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        status_t                   status;
        logic signed [VALUE_W-1:0] max_value;
        logic [COUNT_W-1:0]        entry_count;
    } rsp_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_EXEC,
        CS_SCAN,
        CS_SHIFT,
        CS_RESP
    } ctrl_state_t;

    typedef struct packed {
        logic    load;
        logic    append;
        logic    clear;
        logic    dec;
        logic    scan;
        logic    shift;
        logic    status_set;
        status_t status_code;
        logic    res_load;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic full;
        logic hit;
        logic drained;
        logic best_vld;
        logic rsp_free;
    } dp_sts_t;

endpackage

@@ rtl/blist_ctrl.sv @@
module blist_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  blist_pkg::dp_sts_t sts,
    output blist_pkg::dp_cmd_t cmd
);
    import blist_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = CS_EXEC;
                end
            end
            CS_EXEC:
            begin
                if (sts.op == OP_DELETE || sts.op == OP_MAX)
                begin
                    state_next = CS_SCAN;
                end
                else
                begin
                    state_next = CS_RESP;
                end
            end
            CS_SCAN:
            begin
                priority if (sts.op == OP_DELETE && sts.hit)
                begin
                    state_next = CS_SHIFT;
                end
                else if (sts.drained)
                begin
                    state_next = CS_RESP;
                end
                else
                begin
                    state_next = CS_SCAN;
                end
            end
            CS_SHIFT:
            begin
                if (sts.drained)
                begin
                    state_next = CS_RESP;
                end
            end
            CS_RESP:
            begin
                if (sts.rsp_free)
                begin
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd = '0;
        cmd.status_code = ST_DONE;
        req_stall = (state_reg != CS_IDLE);
        unique case (state_reg)
            CS_IDLE:
            begin
                cmd.load = req_valid;
            end
            CS_EXEC:
            begin
                unique case (sts.op)
                    OP_APPEND:
                    begin
                        cmd.status_set = 1'b1;
                        if (sts.full)
                        begin
                            cmd.status_code = ST_FULL;
                        end
                        else
                        begin
                            cmd.append = 1'b1;
                        end
                    end
                    OP_CLEAR:
                    begin
                        cmd.clear      = 1'b1;
                        cmd.status_set = 1'b1;
                    end
                    default:
                    begin
                        cmd.status_set = 1'b0;
                    end
                endcase
            end
            CS_SCAN:
            begin
                cmd.scan = 1'b1;
                if (!(sts.op == OP_DELETE && sts.hit) && sts.drained)
                begin
                    cmd.status_set = 1'b1;
                    if (sts.op == OP_MAX && sts.best_vld)
                    begin
                        cmd.status_code = ST_DONE;
                    end
                    else
                    begin
                        cmd.status_code = ST_MISS;
                    end
                end
            end
            CS_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (sts.drained)
                begin
                    cmd.dec        = 1'b1;
                    cmd.status_set = 1'b1;
                end
            end
            CS_RESP:
            begin
                cmd.res_load = sts.rsp_free;
            end
            default:
            begin
                cmd.load = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/blist_dp.sv @@
module blist_dp #(
    parameter int CAPACITY = 128
) (
    input  logic               clk,
    input  logic               rst_n,
    input  blist_pkg::req_t    req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output blist_pkg::rsp_t    rsp,
    input  blist_pkg::dp_cmd_t cmd,
    output blist_pkg::dp_sts_t sts
);
    import blist_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic signed [VALUE_W-1:0] mem [CAPACITY];

    op_t                       op_reg;
    logic signed [VALUE_W-1:0] val_reg;
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic [CW-1:0]             ptr_reg;
    logic [CW-1:0]             ptr_next;
    logic                      rd_vld_reg;
    logic                      rd_vld_next;
    logic [IW-1:0]             rd_idx_reg;
    logic signed [VALUE_W-1:0] rd_data_reg;
    logic signed [VALUE_W-1:0] best_reg;
    logic signed [VALUE_W-1:0] best_next;
    logic                      best_vld_reg;
    logic                      best_vld_next;
    status_t                   status_reg;
    status_t                   status_next;
    logic                      rsp_valid_reg;
    logic                      rsp_valid_next;
    rsp_t                      rsp_reg;
    rsp_t                      rsp_next;

    logic                      issue;
    logic                      wr_en;
    logic [IW-1:0]             wr_addr;
    logic signed [VALUE_W-1:0] wr_data;

    assign issue = (cmd.scan || cmd.shift) && (ptr_reg < count_reg);

    // single write port: append at the tail, or move an entry down one place
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = count_reg[IW-1:0];
        wr_data = val_reg;
        if (cmd.append)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.shift && rd_vld_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = rd_idx_reg - IW'(1);
            wr_data = rd_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (issue)
        begin
            rd_data_reg <= mem[ptr_reg[IW-1:0]];
            rd_idx_reg  <= ptr_reg[IW-1:0];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (cmd.append)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.dec)
        begin
            count_next = count_reg - CW'(1);
        end

        ptr_next    = ptr_reg;
        rd_vld_next = issue;
        if (cmd.load)
        begin
            ptr_next = '0;
        end
        else if (issue)
        begin
            ptr_next = ptr_reg + CW'(1);
        end

        best_next     = best_reg;
        best_vld_next = best_vld_reg;
        if (cmd.load)
        begin
            best_vld_next = 1'b0;
        end
        else if (cmd.scan && rd_vld_reg && (!best_vld_reg || rd_data_reg > best_reg))
        begin
            best_next     = rd_data_reg;
            best_vld_next = 1'b1;
        end

        status_next = status_reg;
        if (cmd.status_set)
        begin
            status_next = cmd.status_code;
        end

        rsp_valid_next = rsp_valid_reg;
        if (cmd.res_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        rsp_next.status      = status_reg;
        rsp_next.entry_count = COUNT_W'(count_reg);
        if (op_reg == OP_MAX)
        begin
            rsp_next.max_value = best_vld_reg ? best_reg : MAX_NEG;
        end
        else
        begin
            rsp_next.max_value = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            best_vld_reg  <= 1'b0;
            status_reg    <= ST_DONE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            rd_vld_reg    <= rd_vld_next;
            best_vld_reg  <= best_vld_next;
            status_reg    <= status_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= req.op;
            val_reg <= req.value;
        end
        best_reg <= best_next;
        if (cmd.res_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign sts.op       = op_reg;
    assign sts.full     = (count_reg >= CAP_C);
    assign sts.hit      = rd_vld_reg && (rd_data_reg == val_reg);
    assign sts.drained  = !rd_vld_reg && (ptr_reg >= count_reg);
    assign sts.best_vld = best_vld_reg;
    assign sts.rsp_free = !rsp_valid_reg || !rsp_stall;

endmodule

@@ rtl/bounded_list_append_delete_max.sv @@
// append and clear: executed in EXEC, response register loaded in RESP once free
// delete and max: the SCAN state reads one store entry per cycle through the
// single read port; a delete then moves each later entry down one per cycle
// the next request is taken in the cycle after the response register is loaded
// reset: live count zero, response register empty; store contents undefined,
// no clearing pass
module bounded_list_append_delete_max #(
    parameter int CAPACITY = 128
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  blist_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output blist_pkg::rsp_t rsp
);
    import blist_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    blist_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    blist_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

@@ tb/bounded_list_append_delete_max_tb.sv @@
module bounded_list_append_delete_max_tb;

    import blist_pkg::*;

    localparam int LIST_CAPACITY = 128;
    localparam int STALL_LIMIT   = 5000;
    localparam int HOLDOFF_LEN   = 400;
    localparam int DRAIN_CYCLES  = 2 * LIST_CAPACITY + 20;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    logic signed [VALUE_W-1:0] list_vals [LIST_CAPACITY];
    int   list_len = 0;
    rsp_t expected_rsps [$];
    int   fail_count = 0;
    int   send_idle_pct = 0;
    int   rsp_stall_pct = 0;
    int   holdoff_len = 0;
    bit   holdoff_go = 1'b0;
    bit   holdoff_seen = 1'b0;
    int   holdoff_left = 0;
    int   quiet_cycles = 0;

    bounded_list_append_delete_max #(
        .CAPACITY(LIST_CAPACITY)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    always #10 clk = ~clk;

    function automatic rsp_t apply_list_op(req_t r);
        rsp_t res;
        int pos;
        int k;
        bit found;
        logic signed [VALUE_W-1:0] best;
        res.status = ST_DONE;
        res.max_value = '0;
        case (r.op)
            OP_APPEND:
            begin
                if (list_len < LIST_CAPACITY)
                begin
                    list_vals[list_len] = r.value;
                    list_len++;
                end
                else
                begin
                    res.status = ST_FULL;
                end
            end
            OP_CLEAR:
            begin
                list_len = 0;
            end
            OP_DELETE:
            begin
                found = 1'b0;
                pos = 0;
                while (pos < list_len && !found)
                begin
                    if (list_vals[pos] == r.value)
                        found = 1'b1;
                    else
                        pos++;
                end
                if (found)
                begin
                    for (k = pos; k + 1 < list_len; k++)
                        list_vals[k] = list_vals[k + 1];
                    list_len--;
                end
                else
                begin
                    res.status = ST_MISS;
                end
            end
            default:
            begin
                if (list_len == 0)
                begin
                    res.max_value = MAX_NEG;
                    res.status = ST_MISS;
                end
                else
                begin
                    best = list_vals[0];
                    for (k = 1; k < list_len; k++)
                        if (list_vals[k] > best)
                            best = list_vals[k];
                    res.max_value = best;
                end
            end
        endcase
        res.entry_count = COUNT_W'(list_len);
        return res;
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 50 && list_len > 0)
            return list_vals[$urandom_range(list_len - 1)];
        if (sel < 75)
            return VALUE_W'($urandom_range(8)) - 4;
        if (sel < 82)
            return ($urandom_range(1) != 0) ? 32'sh7fffffff : MAX_NEG;
        return $urandom;
    endfunction

    task automatic send_request(input op_t op, input logic signed [VALUE_W-1:0] value);
        req_t item;
        item.op = op;
        item.value = value;
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        do
            @(posedge clk);
        while (req_stall);
        expected_rsps.push_back(apply_list_op(item));
    endtask

    task automatic test_directed_cases();
        send_request(OP_MAX, 0);
        send_request(OP_DELETE, 7);
        send_request(OP_APPEND, 32'sh7fffffff);
        send_request(OP_APPEND, MAX_NEG);
        send_request(OP_APPEND, 0);
        send_request(OP_APPEND, -1);
        send_request(OP_MAX, 0);
        send_request(OP_DELETE, 0);
        send_request(OP_DELETE, 12345);
        send_request(OP_APPEND, 5);
        send_request(OP_APPEND, 5);
        send_request(OP_APPEND, -5);
        send_request(OP_DELETE, 5);
        send_request(OP_MAX, 0);
        send_request(OP_DELETE, 32'sh7fffffff);
        send_request(OP_MAX, 0);
        send_request(OP_DELETE, -5);
        send_request(OP_MAX, 0);
        send_request(OP_CLEAR, 32'sh0f0f0f0f);
        send_request(OP_MAX, 0);
        send_request(OP_DELETE, 5);
        send_request(OP_APPEND, 32'sh55555555);
        send_request(OP_APPEND, 32'shaaaaaaaa);
        send_request(OP_MAX, -1);
        send_request(OP_CLEAR, 0);
    endtask

    task automatic test_full_under_backpressure();
        int n;
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        holdoff_len = HOLDOFF_LEN;
        holdoff_go = ~holdoff_go;
        for (n = 0; n < LIST_CAPACITY + 3; n++)
            send_request(OP_APPEND, $urandom);
        send_request(OP_MAX, 0);
        send_request(OP_DELETE, list_vals[LIST_CAPACITY - 1]);
        send_request(OP_DELETE, list_vals[0]);
        send_request(OP_MAX, 0);
        send_request(OP_APPEND, MAX_NEG);
        send_request(OP_APPEND, 32'sh7fffffff);
        send_request(OP_APPEND, 1);
        send_request(OP_MAX, 0);
        send_request(OP_DELETE, MAX_NEG);
    endtask

    task automatic test_pause_until_drained();
        req_valid <= 1'b0;
        while (expected_rsps.size() != 0)
            @(posedge clk);
        send_request(OP_MAX, 0);
        send_request(OP_CLEAR, 0);
        send_request(OP_DELETE, 0);
    endtask

    task automatic test_random_mix(input int count, input int idle_pct, input int stall_pct);
        int n;
        int sel;
        op_t op;
        send_idle_pct = idle_pct;
        rsp_stall_pct = stall_pct;
        for (n = 0; n < count; n++)
        begin
            sel = $urandom_range(99);
            if (sel < 44)
                op = OP_APPEND;
            else if (sel < 72)
                op = OP_DELETE;
            else if (sel < 96)
                op = OP_MAX;
            else
                op = OP_CLEAR;
            send_request(op, pick_value());
        end
    endtask

    always @(posedge clk)
    begin
        if (rsp_valid && !rsp_stall)
        begin
            if (expected_rsps.size() == 0)
            begin
                $error("response with nothing outstanding: %h", rsp);
                fail_count++;
            end
            else
            begin
                if (rsp.status !== expected_rsps[0].status)
                begin
                    $error("status: expected %0d, got %0d", expected_rsps[0].status, rsp.status);
                    fail_count++;
                end
                if (rsp.max_value !== expected_rsps[0].max_value)
                begin
                    $error("max_value: expected %0d, got %0d",
                        expected_rsps[0].max_value, rsp.max_value);
                    fail_count++;
                end
                if (rsp.entry_count !== expected_rsps[0].entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d",
                        expected_rsps[0].entry_count, rsp.entry_count);
                    fail_count++;
                end
                void'(expected_rsps.pop_front());
            end
        end
        if (holdoff_go != holdoff_seen)
        begin
            holdoff_seen = holdoff_go;
            holdoff_left = holdoff_len;
        end
        if (holdoff_left > 0)
        begin
            holdoff_left--;
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_full_under_backpressure();
        test_pause_until_drained();
        test_random_mix(70, 0, 0);
        test_random_mix(70, 48, 0);
        test_random_mix(70, 0, 48);
        test_random_mix(70, 27, 27);
        req_valid <= 1'b0;
        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_rsps.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/blist_pkg.sv
rtl/blist_ctrl.sv
rtl/blist_dp.sv
rtl/bounded_list_append_delete_max.sv
tb/bounded_list_append_delete_max_tb.sv
